### sv/swam_pkg.sv
// Shared types, codes and helpers for the segmented window address map.
`timescale 1ns / 1ps

package swam_pkg;

	localparam int POS_W  = 48;
	localparam int TIER_W = 32;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ADD    = 2'd1,
		OP_UNHASH = 2'd2,
		OP_HASH   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOINIT = 3'd1,
		ST_RANGE  = 3'd2,
		ST_NOTIER = 3'd3,
		ST_LOCAL  = 3'd4,
		ST_FULL   = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [TIER_W-1:0] tier_id;
		logic [POS_W-1:0]  tier_size;
		logic [POS_W-1:0]  local_position;
		logic [POS_W-1:0]  window_position;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [TIER_W-1:0] out_tier;
		logic [POS_W-1:0]  out_position;
		logic [POS_W-1:0]  total_positions;
		logic              loopy;
	} rsp_t;

	// one segment as stored in the table memory
	typedef struct packed {
		logic [TIER_W-1:0] tier;
		logic [POS_W-1:0]  end_off;
	} seg_entry_t;

	// saturating add at the position width
	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
	                                             input logic [POS_W-1:0] b);
		logic [POS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
	endfunction

endpackage

### sv/swam_store.sv
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module swam_store #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  swam_pkg::seg_entry_t           wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output swam_pkg::seg_entry_t           rdata
);

	swam_pkg::seg_entry_t mem [DEPTH];
	swam_pkg::seg_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/swam_ctrl.sv
// Request decode, window state and the table scan sequencer.
`timescale 1ns / 1ps

module swam_ctrl #(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  swam_pkg::req_t                    req,
	output logic                              busy,
	output logic                              rsp_vld,
	output swam_pkg::rsp_t                    rsp,
	output logic                              mem_we,
	output logic [$clog2(MAX_SEGMENTS)-1:0]   mem_waddr,
	output swam_pkg::seg_entry_t              mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(MAX_SEGMENTS)-1:0]   mem_raddr,
	input  swam_pkg::seg_entry_t              mem_rdata
);

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
	localparam int POS_W = swam_pkg::POS_W;
	localparam int TIER_W = swam_pkg::TIER_W;

	swam_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic              valid_q;
	logic              loopy_q;
	logic [TIER_W-1:0] home_q;
	logic [POS_W-1:0]  total_q;

	// scan context
	logic              is_hash_q;
	logic [TIER_W-1:0] key_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  base_q;
	logic [CNT_W-1:0]  raddr_q;
	logic              rd_vld_s1;

	logic              accept;
	logic              need_scan;
	logic              home_hit;
	logic              full;
	logic              wpos_range;
	logic [POS_W-1:0]  new_total;
	logic              scan_hit;
	logic              scan_miss;
	logic [POS_W:0]    hash_sum;
	logic              local_bad;

	assign accept     = start && (state_q == swam_pkg::S_IDLE);
	assign new_total  = swam_pkg::sat_add(total_q, req.tier_size);
	assign home_hit   = (req.tier_id == home_q);
	assign full       = (count_q == CNT_MAX);
	assign wpos_range = (req.window_position >= total_q);
	assign need_scan  = accept && valid_q &&
		((req.op == swam_pkg::OP_HASH) ||
		 ((req.op == swam_pkg::OP_UNHASH) && !wpos_range));

	// compare stage on the registered read data
	assign hash_sum  = {1'b0, base_q} + {1'b0, pos_q};
	assign local_bad = (hash_sum >= {1'b0, mem_rdata.end_off});
	assign scan_hit  = rd_vld_s1 && (is_hash_q ? (mem_rdata.tier == key_q)
	                                           : (pos_q < mem_rdata.end_off));
	assign scan_miss = !rd_vld_s1 && (raddr_q == count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swam_pkg::S_IDLE: begin
				if (need_scan) begin
					state_d = swam_pkg::S_SCAN;
				end
			end
			swam_pkg::S_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_d = swam_pkg::S_IDLE;
				end
			end
			default: state_d = swam_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy                = (state_q != swam_pkg::S_IDLE);
		rsp_vld             = 1'b0;
		rsp.status          = swam_pkg::ST_OK;
		rsp.out_tier        = '0;
		rsp.out_position    = '0;
		rsp.total_positions = valid_q ? total_q : '0;
		rsp.loopy           = loopy_q;
		mem_we              = 1'b0;
		mem_waddr           = count_q[IDX_W-1:0];
		mem_wdata.tier      = req.tier_id;
		mem_wdata.end_off   = new_total;
		mem_re              = 1'b0;
		mem_raddr           = raddr_q[IDX_W-1:0];
		unique case (state_q)
			swam_pkg::S_IDLE: begin
				if (accept) begin
					rsp_vld = !need_scan;
					if (req.op == swam_pkg::OP_START) begin
						mem_we              = 1'b1;
						mem_waddr           = '0;
						mem_wdata.end_off   = req.tier_size;
						rsp.total_positions = req.tier_size;
						rsp.loopy           = 1'b0;
					end else if (!valid_q) begin
						rsp.status = swam_pkg::ST_NOINIT;
					end else if (req.op == swam_pkg::OP_ADD) begin
						if (home_hit) begin
							rsp.loopy = 1'b1;
						end else if (full) begin
							rsp.status = swam_pkg::ST_FULL;
						end else begin
							mem_we              = 1'b1;
							rsp.total_positions = new_total;
						end
					end else if (req.op == swam_pkg::OP_UNHASH) begin
						rsp.status = swam_pkg::ST_RANGE;  // only seen when not scanning
					end
				end
			end
			swam_pkg::S_SCAN: begin
				mem_re = (raddr_q < count_q) && !scan_hit;
				if (scan_hit) begin
					rsp_vld = 1'b1;
					if (is_hash_q) begin
						if (local_bad) begin
							rsp.status = swam_pkg::ST_LOCAL;
						end else begin
							rsp.out_position = hash_sum[POS_W-1:0];
						end
					end else begin
						rsp.out_tier     = mem_rdata.tier;
						rsp.out_position = pos_q - base_q;
					end
				end else if (scan_miss) begin
					rsp_vld    = 1'b1;
					rsp.status = is_hash_q ? swam_pkg::ST_NOTIER : swam_pkg::ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= swam_pkg::S_IDLE;
			count_q   <= '0;
			valid_q   <= 1'b0;
			loopy_q   <= 1'b0;
			raddr_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (mem_re) begin
				raddr_q <= raddr_q + CNT_W'(1);
			end
			if (accept) begin
				raddr_q <= '0;
				if (req.op == swam_pkg::OP_START) begin
					count_q <= CNT_W'(1);
					valid_q <= 1'b1;
					loopy_q <= 1'b0;
				end else if (valid_q && (req.op == swam_pkg::OP_ADD)) begin
					if (home_hit) begin
						loopy_q <= 1'b1;
					end else if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_hash_q <= (req.op == swam_pkg::OP_HASH);
			key_q     <= req.tier_id;
			pos_q     <= (req.op == swam_pkg::OP_HASH) ? req.local_position
			                                           : req.window_position;
			base_q    <= '0;
			if (req.op == swam_pkg::OP_START) begin
				home_q  <= req.tier_id;
				total_q <= req.tier_size;
			end else if (valid_q && (req.op == swam_pkg::OP_ADD) && !home_hit && !full) begin
				total_q <= new_total;
			end
		end else if (rd_vld_s1 && !scan_hit) begin
			base_q <= mem_rdata.end_off;  // start of the next segment
		end
	end

endmodule

### sv/segmented_window_address_map_top.sv
// Top level of the segmented window address map: control, table memory, result register.
`timescale 1ns / 1ps

// Maps between a flat window of positions and (tier, local position) pairs over a table
// of up to MAX_SEGMENTS segments, each holding a tier id and its running end offset.
// A request is taken when start is high and busy is low; its single result shows on rsp
// for exactly one cycle with done high and cannot be held off, so a consumer must take
// it then. Start, add and any request rejected up front finish without a scan: the result
// appears the cycle after acceptance and busy never rises, so these can be issued every
// cycle. Unhash and hash walk the table through the memory's one read port, one entry
// per cycle, with the read data registered in the memory: busy stays high during the scan
// and the result appears in the cycle that busy falls. Table writes happen only
// from the idle state and reads only while scanning, so accesses never overlap.
// The table has no clearing pass; only entries below the segment count are read.

module segmented_window_address_map_top #(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  swam_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output swam_pkg::rsp_t rsp
);

	localparam int IDX_W = $clog2(MAX_SEGMENTS);

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	swam_pkg::seg_entry_t mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	swam_pkg::seg_entry_t mem_rdata;

	logic                 rsp_vld;
	swam_pkg::rsp_t       rsp_d;

	logic                 done_q;
	swam_pkg::rsp_t       rsp_q;

	swam_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.rsp_vld  (rsp_vld),
		.rsp      (rsp_d),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	swam_store #(
		.DEPTH(MAX_SEGMENTS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_vld) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// a start request always answers OK on the next cycle
	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.op == swam_pkg::OP_START)
		|=> done && (rsp.status == swam_pkg::ST_OK))
		else $error("start request did not complete OK");

	// a scan ends with its result
	a_scan_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan finished without a result");

	// results only show while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// failed requests carry no translation
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != swam_pkg::ST_OK)
		|-> (rsp.out_tier == '0) && (rsp.out_position == '0))
		else $error("failed request returned a translation");

endmodule
